@@ rtl/sbi_pkg.sv @@
// Shared constants and register indexes for the segment/box intersection block.
package sbi_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_e;

endpackage

@@ rtl/segment_box_intersect.sv @@
// Segment versus axis-aligned box test, fully pipelined slab method.
//
// One word is taken and one hit flag delivered per clock when both sides
// keep flowing. The pipeline is an input register, a slab classification
// stage, one restoring-divider stage per quotient bit (three dividers side
// by side, one per axis), a stage that picks the largest plane parameter, a
// multiply stage and a final bounds check that feeds the output
// register. Every stage holds its own valid bit and moves on whenever the
// stage after it is empty or moving, so bubbles close up under stall. The box
// registers are meant to be written only while no word is in flight.
module segment_box_intersect #(
  parameter int unsigned COORD_W = sbi_pkg::COORD_WIDTH,
  parameter int unsigned FRAC_W  = sbi_pkg::FRAC_BITS,
  localparam int unsigned IN_W   = ((6 * COORD_W + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sbi_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COORD_W-1:0]             cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // start_x, start_y, start_z, delta_x, delta_y, delta_z (lowest first)
  input  logic [IN_W-1:0]                s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // hit
  output logic [7:0]                     m_axis_tdata_o
);

  import sbi_pkg::*;

  localparam int unsigned W   = COORD_W;
  localparam int unsigned F   = FRAC_W;
  localparam int unsigned TW  = F + 2;
  localparam int unsigned PW  = W + TW;
  localparam int unsigned CW  = W + 3;
  localparam int unsigned NST = F + 5;
  localparam int unsigned ST_CLS  = 1;
  localparam int unsigned ST_PICK = F + 2;
  localparam int unsigned ST_MUL  = F + 3;
  localparam int unsigned ST_CHK  = F + 4;
  localparam logic signed [TW-1:0] T_ONE = TW'(1) << F;
  localparam logic signed [TW-1:0] T_NEG = -(TW'(1) << F);

  typedef struct {
    logic signed [W-1:0]  s    [3];
    logic signed [W-1:0]  d    [3];
    logic        [W-1:0]  r    [3];
    logic        [W-1:0]  mag  [3];
    logic        [F-1:0]  q    [3];
    logic                 one  [3];
    logic                 outs [3];
    logic                 rej;
    logic signed [TW-1:0] best;
    logic        [1:0]    w;
    logic signed [PW-1:0] prod [3];
    logic                 hit;
  } item_t;

  logic signed [W-1:0] lo_q [3];
  logic signed [W-1:0] hi_q [3];

  item_t stg_q [NST];
  item_t stg_d [NST];
  logic  v_q   [NST];
  logic  rdy   [NST+1];

  // box registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_X: lo_q[0] <= cfg_data_i;
        REG_MIN_Y: lo_q[1] <= cfg_data_i;
        REG_MIN_Z: lo_q[2] <= cfg_data_i;
        REG_MAX_X: hi_q[0] <= cfg_data_i;
        REG_MAX_Y: hi_q[1] <= cfg_data_i;
        REG_MAX_Z: hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic item_t classify(item_t x);
    item_t                y;
    logic                 below;
    logic                 above;
    logic signed [W:0]    diff;
    logic signed [W:0]    neg;
    y = x;
    y.rej = 1'b0;
    for (int i = 0; i < 3; i++) begin
      below = x.s[i] < lo_q[i];
      above = !below && (x.s[i] > hi_q[i]);
      y.outs[i] = below || above;
      neg = -{x.d[i][W-1], x.d[i]};
      if (below) begin
        diff = {lo_q[i][W-1], lo_q[i]} - {x.s[i][W-1], x.s[i]};
        y.mag[i] = x.d[i];
        if (x.d[i] <= 0) y.rej = 1'b1;
      end else begin
        diff = {x.s[i][W-1], x.s[i]} - {hi_q[i][W-1], hi_q[i]};
        y.mag[i] = neg[W-1:0];
        if (above && x.d[i] >= 0) y.rej = 1'b1;
      end
      y.r[i] = diff[W-1:0];
      y.q[i] = '0;
      y.one[i] = (y.r[i] == y.mag[i]);
      if (y.outs[i] && (y.r[i] > y.mag[i])) y.rej = 1'b1;
    end
    return y;
  endfunction

  function automatic item_t div_step(item_t x);
    item_t        y;
    logic [W:0]   r2;
    y = x;
    for (int i = 0; i < 3; i++) begin
      r2 = {x.r[i], 1'b0};
      if (r2 >= {1'b0, x.mag[i]}) begin
        r2 = r2 - {1'b0, x.mag[i]};
        y.q[i] = {x.q[i][F-2:0], 1'b1};
      end else begin
        y.q[i] = {x.q[i][F-2:0], 1'b0};
      end
      y.r[i] = r2[W-1:0];
    end
    return y;
  endfunction

  function automatic item_t pick(item_t x);
    item_t                y;
    logic signed [TW-1:0] t [3];
    y = x;
    for (int i = 0; i < 3; i++) begin
      if (!x.outs[i])    t[i] = T_NEG;
      else if (x.one[i]) t[i] = T_ONE;
      else               t[i] = {2'b00, x.q[i]};
    end
    y.best = t[0];
    y.w    = 2'd0;
    if (y.best < t[1]) begin
      y.best = t[1];
      y.w    = 2'd1;
    end
    if (y.best < t[2]) begin
      y.best = t[2];
      y.w    = 2'd2;
    end
    return y;
  endfunction

  function automatic item_t mul(item_t x);
    item_t y;
    y = x;
    for (int i = 0; i < 3; i++)
      y.prod[i] = PW'(x.d[i]) * PW'(x.best);
    return y;
  endfunction

  function automatic item_t check(item_t x);
    item_t                y;
    logic signed [PW-1:0] sh;
    logic signed [CW-1:0] c;
    logic                 ok;
    y = x;
    ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      sh = x.prod[i] >>> F;
      c  = CW'(x.s[i]) + CW'(sh);
      if ((i != int'(x.w)) && ((c < CW'(lo_q[i])) || (c > CW'(hi_q[i])))) ok = 1'b0;
    end
    if (x.outs[0] || x.outs[1] || x.outs[2])
      y.hit = !x.rej && ok && (x.best >= 0) && (x.best <= T_ONE);
    else
      y.hit = !x.rej;
    return y;
  endfunction

  always_comb begin
    stg_d[0] = stg_q[0];
    for (int i = 0; i < 3; i++) begin
      stg_d[0].s[i] = s_axis_tdata_i[i*W +: W];
      stg_d[0].d[i] = s_axis_tdata_i[(3+i)*W +: W];
    end
    stg_d[ST_CLS] = classify(stg_q[0]);
    for (int k = ST_CLS + 1; k < ST_PICK; k++)
      stg_d[k] = div_step(stg_q[k-1]);
    stg_d[ST_PICK] = pick(stg_q[ST_PICK-1]);
    stg_d[ST_MUL]  = mul(stg_q[ST_MUL-1]);
    stg_d[ST_CHK]  = check(stg_q[ST_CHK-1]);
  end

  // a stage may load when empty or when the next one loads
  always_comb begin
    rdy[NST] = m_axis_tready_i;
    for (int k = NST - 1; k >= 0; k--)
      rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) v_q[k] <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NST; k++)
        if (rdy[k]) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid_i) stg_q[0] <= stg_d[0];
    for (int k = 1; k < NST; k++)
      if (rdy[k] && v_q[k-1]) stg_q[k] <= stg_d[k];
  end

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = v_q[NST-1];
  assign m_axis_tdata_o  = {7'b0, stg_q[NST-1].hit};

endmodule

@@ dv/segment_box_intersect_tb.sv @@
// Self-checking testbench for the segment/box intersection block.
`timescale 1ns / 100ps

module segment_box_intersect_tb;
  import sbi_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned IN_W = ((6 * CW + 7) / 8) * 8;
  localparam int unsigned LATENCY = FB + 5;
  localparam int unsigned WATCHDOG = 20000;
  localparam int unsigned N_RANDOM = 1330;
  localparam logic signed [63:0] T_ONE = 64'sd1 <<< FB;

  typedef struct packed {
    logic [CW-1:0] dz, dy, dx, sz, sy, sx;
  } seg_t;

  typedef struct {
    seg_t seg;
    int   hit;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // start_x, start_y, start_z, delta_x, delta_y, delta_z (lowest first)
  logic [IN_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // hit
  logic [7:0] m_axis_tdata_o;

  always #6 clk_i = ~clk_i;

  segment_box_intersect dut (.*);

  logic signed [63:0] box_lo [3];
  logic signed [63:0] box_hi [3];
  logic hit_q [$];
  int   errors = 0;
  int   idle_cnt = 0;
  bit   calm = 1'b0;

  function automatic logic signed [63:0] plane_param(logic signed [63:0] n,
                                                     logic signed [63:0] d);
    logic signed [63:0] r, q;
    r = n;
    q = 0;
    if (n >= d) return T_ONE;
    for (int i = 0; i < FB; i++) begin
      q = q <<< 1;
      if (r >= d - r) begin
        r = r - (d - r);
        q = q | 1;
      end else begin
        r = r + r;
      end
    end
    return q;
  endfunction

  function automatic logic predict_hit(seg_t g);
    logic signed [63:0] s [3], d [3], t [3], gap, mag, best, c;
    logic outside;
    int w;
    outside = 1'b0;
    s[0] = signed'(g.sx); s[1] = signed'(g.sy); s[2] = signed'(g.sz);
    d[0] = signed'(g.dx); d[1] = signed'(g.dy); d[2] = signed'(g.dz);
    for (int i = 0; i < 3; i++) begin
      if (s[i] < box_lo[i]) begin
        gap = box_lo[i] - s[i];
        if (d[i] <= 0) return 1'b0;
        mag = d[i];
      end else if (s[i] > box_hi[i]) begin
        gap = s[i] - box_hi[i];
        if (d[i] >= 0) return 1'b0;
        mag = -d[i];
      end else begin
        t[i] = -T_ONE;
        continue;
      end
      if (gap > mag) return 1'b0;
      t[i] = plane_param(gap, mag);
      outside = 1'b1;
    end
    if (!outside) return 1'b1;
    w = 0;
    best = t[0];
    if (best < t[1]) begin w = 1; best = t[1]; end
    if (best < t[2]) begin w = 2; best = t[2]; end
    for (int i = 0; i < 3; i++) begin
      if (i == w) continue;
      c = s[i] + ((d[i] * best) >>> FB);
      if (c < box_lo[i] || c > box_hi[i]) return 1'b0;
    end
    return best >= 0 && best <= T_ONE;
  endfunction

  function automatic logic [CW-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return CW'(signed'($urandom_range(0, 40 << FB)) - (20 << FB));
    endcase
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [CW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    unique case (idx)
      REG_MIN_X: box_lo[0] = signed'(val);
      REG_MIN_Y: box_lo[1] = signed'(val);
      REG_MIN_Z: box_lo[2] = signed'(val);
      REG_MAX_X: box_hi[0] = signed'(val);
      REG_MAX_Y: box_hi[1] = signed'(val);
      REG_MAX_Z: box_hi[2] = signed'(val);
      default: ;
    endcase
  endtask

  task automatic set_box(logic [CW-1:0] lx, ly, lz, hx, hy, hz);
    s_axis_tvalid_i <= 1'b0;
    wait (hit_q.size() == 0);
    repeat (LATENCY + 2) @(posedge clk_i);
    write_reg(REG_MIN_X, lx); write_reg(REG_MIN_Y, ly); write_reg(REG_MIN_Z, lz);
    write_reg(REG_MAX_X, hx); write_reg(REG_MAX_Y, hy); write_reg(REG_MAX_Z, hz);
  endtask

  // leaves tvalid high after the accepting edge; the caller drops it before any pause
  task automatic send_seg(seg_t g);
    while (!calm && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_W'(g);
    do @(posedge clk_i); while (!s_axis_tready_o);
    hit_q.push_back(predict_hit(g));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready_i <= calm || $urandom_range(0, 99) >= 6;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (hit_q.size() == 0) begin
          $error("unexpected hit word: actual %0d", m_axis_tdata_o[0]);
          errors++;
        end else begin
          if (m_axis_tdata_o[0] !== hit_q[0]) begin
            $error("hit: expected %0d actual %0d", hit_q[0], m_axis_tdata_o[0]);
            errors++;
          end
          void'(hit_q.pop_front());
        end
      end
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o)
          || (cfg_valid_i && cfg_ready_o) || hit_q.size() == 0)
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
        $display("segment_box_intersect_tb failed");
        $finish;
      end
    end
  end

  localparam logic [CW-1:0] ONE = 1 << FB;
  localparam logic [CW-1:0] MONE = -(1 << FB);

  dir_row_t dir_rows [] = '{
    // reset box is the origin point
    '{'{dz: 0, dy: 0, dx: 0, sz: 0, sy: 0, sx: 0}, 1},
    '{'{dz: 0, dy: 0, dx: 0, sz: 0, sy: 0, sx: ONE}, 0},
    '{'{dz: 0, dy: 0, dx: MONE, sz: 0, sy: 0, sx: ONE}, -1},
    '{'{dz: 0, dy: 0, dx: ONE, sz: 0, sy: 0, sx: ONE}, 0},
    '{'{dz: 0, dy: 0, dx: -2*ONE, sz: 0, sy: 0, sx: ONE}, -1},
    '{'{dz: ONE, dy: ONE, dx: MONE, sz: 0, sy: 0, sx: ONE}, -1},
    '{'{dz: 32'h8000_0000, dy: 32'h8000_0000, dx: 32'h8000_0000,
        sz: 32'h7fff_ffff, sy: 32'h7fff_ffff, sx: 32'h7fff_ffff}, -1},
    '{'{dz: 32'h7fff_ffff, dy: 32'h7fff_ffff, dx: 32'h7fff_ffff,
        sz: 32'h8000_0000, sy: 32'h8000_0000, sx: 32'h8000_0000}, -1},
    '{'{dz: '1, dy: '1, dx: '1, sz: '1, sy: '1, sx: '1}, 0}
  };

  seg_t g;
  initial begin
    box_lo = '{default: 0};
    box_hi = '{default: 0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].hit >= 0 && predict_hit(dir_rows[i].seg) !== dir_rows[i].hit[0]) begin
        $error("hit: expected %0d actual %0d (table row %0d)", dir_rows[i].hit,
               predict_hit(dir_rows[i].seg), i);
        errors++;
      end
      send_seg(dir_rows[i].seg);
    end
    // unit box, then a degenerate box, then the full range
    set_box(MONE, MONE, MONE, ONE, ONE, ONE);
    foreach (dir_rows[i]) send_seg(dir_rows[i].seg);
    set_box(ONE, 0, MONE, MONE, 0, ONE);
    foreach (dir_rows[i]) send_seg(dir_rows[i].seg);
    set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    foreach (dir_rows[i]) send_seg(dir_rows[i].seg);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 0) begin
        logic signed [CW-1:0] a, b;
        logic [CW-1:0] lo [3], hi [3];
        for (int k = 0; k < 3; k++) begin
          a = rnd_coord();
          b = $urandom_range(0, 9) == 0 ? rnd_coord() : a + CW'($urandom_range(0, 8 << FB));
          lo[k] = a; hi[k] = b;
        end
        set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
      end
      calm = (n >= 400 && n < 600);
      if (n == 700) begin
        s_axis_tvalid_i <= 1'b0;
        wait (hit_q.size() == 0);
      end
      g.sx = rnd_coord(); g.sy = rnd_coord(); g.sz = rnd_coord();
      if ($urandom_range(0, 3) != 0) begin
        // aim at a point near the box so that many segments reach it
        g.dx = CW'(box_lo[0] + signed'(CW'($urandom_range(0, 4 << FB))) - signed'(g.sx));
        g.dy = CW'(box_lo[1] + signed'(CW'($urandom_range(0, 4 << FB))) - signed'(g.sy));
        g.dz = CW'(box_lo[2] + signed'(CW'($urandom_range(0, 4 << FB))) - signed'(g.sz));
      end else begin
        g.dx = rnd_coord(); g.dy = rnd_coord(); g.dz = rnd_coord();
      end
      send_seg(g);
    end
    calm = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    wait (hit_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (errors == 0) $display("segment_box_intersect_tb passed");
    else $display("segment_box_intersect_tb failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/sbi_pkg.sv
rtl/segment_box_intersect.sv
dv/segment_box_intersect_tb.sv
